/* rtl/sdw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdw_pkg: shared types, constants and weight table
// Widths, piece geometry, the command and status bundles between the
// controller and the datapath, and the -ln(binomial tail) table in Q16.16.
// ----------------------------------------------------------------------------
package sdw_pkg;

    // Piece geometry and limits
    localparam int PIECE_LEN = 10;
    localparam int MAX_DIAG  = 4095;

    // Field widths
    localparam int LEN_W    = 12;
    localparam int SIM_W    = 12;
    localparam int WEIGHT_W = 32;

    // Piece length 0..PIECE_LEN, count before saturation 0..PIECE_LEN+1
    localparam int N_W   = $clog2(PIECE_LEN + 1);
    localparam int CNT_W = $clog2(PIECE_LEN + 2);
    localparam int IDX_W = $clog2(N_W);

    // Divider dividend sim * piece_len
    localparam int PROD_W = SIM_W + N_W;

    // Reciprocal for len / PIECE_LEN, exact over all LEN_W-bit lengths
    localparam int RECIP_SHIFT = LEN_W + N_W;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + PIECE_LEN - 1) / PIECE_LEN;
    localparam int RPROD_W     = LEN_W + RECIP_SHIFT;

    // Round-up threshold: remainder * THR_DEN >= THR_NUM * len
    localparam int THR_NUM = 999;
    localparam int THR_DEN = 1000;
    localparam int THR_W   = LEN_W + 10;
    localparam int REM_W   = LEN_W + 2;
    localparam int R1K_W   = REM_W + 10;

    // Log evaluation constants
    localparam logic [63:0] LN2_Q32       = 64'd2977044472;
    localparam int          LOG_FRAC_BITS = 24;

    // Weight table indexed [piece length][count]
    typedef logic [PIECE_LEN:0][PIECE_LEN:0][WEIGHT_W-1:0] weight_tbl_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;          // capture the input item
        logic setup;         // range check, piece count, threshold
        logic split;         // last piece length, start full-piece division
        logic div_step;      // one restoring division step
        logic div_last;      // division result belongs to the last piece
        logic div_load_last; // start last-piece division
        logic piece_step;    // share one piece
        logic piece_last;    // the piece being shared is the last one
        logic result_load;   // move the total into the output register
    } sdw_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bad;       // input rejected
        logic div_done;  // division finishes this cycle
        logic more_full; // full pieces remain
    } sdw_status_t;

    // -ln P(Binomial(n, 0.25) >= k) in Q16.16, count saturated to n
    function automatic logic [WEIGHT_W-1:0] piece_weight(input int unsigned n,
                                                          input int unsigned k);
        logic [63:0] row [PIECE_LEN+1];
        logic [63:0] num;
        logic [63:0] p3;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] prod;
        int unsigned kk;
        int unsigned e;
        int unsigned i;
        int unsigned j;
        kk = (k > n) ? n : k;
        // Binomial coefficients of row n
        for (i = 0; i <= PIECE_LEN; i++) begin
            row[i] = 64'd0;
        end
        row[0] = 64'd1;
        for (i = 1; i <= n; i++) begin
            for (j = i; j >= 1; j--) begin
                row[j] = row[j] + row[j-1];
            end
        end
        // Tail numerator over 4^n
        num = 64'd0;
        for (i = kk; i <= n; i++) begin
            p3 = 64'd1;
            for (j = 0; j < n - i; j++) begin
                p3 = p3 * 64'd3;
            end
            num = num + row[i] * p3;
        end
        // Integer part of log2
        e = 0;
        for (i = 0; i < 63; i++) begin
            if ((num >> (i + 1)) != 64'd0) begin
                e = i + 1;
            end
        end
        m = (e <= 31) ? (num << (31 - e)) : (num >> (e - 31));
        // Fraction bits by repeated squaring
        frac = 64'd0;
        for (i = 0; i < LOG_FRAC_BITS; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        x = (64'(2 * n) << LOG_FRAC_BITS) - ((64'(e) << LOG_FRAC_BITS) | frac);
        prod = x * LN2_Q32 + (64'd1 << 39);
        return WEIGHT_W'(prod >> 40);
    endfunction

    function automatic weight_tbl_t build_weight_tbl();
        weight_tbl_t tbl;
        for (int n = 0; n <= PIECE_LEN; n++) begin
            for (int k = 0; k <= PIECE_LEN; k++) begin
                tbl[n][k] = piece_weight(n, k);
            end
        end
        return tbl;
    endfunction

endpackage
`default_nettype wire

/* rtl/segmented_diagonal_weight.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_diagonal_weight: piecewise binomial weight of one diagonal
// Cuts a diagonal into pieces of PIECE_LEN residues and a shorter last
// piece, spreads the match count over them and sums -ln tail probabilities.
// ----------------------------------------------------------------------------
// One item in, one item out. Between acceptances an item passes through
// setup, two short restoring divisions of one quotient bit per cycle (one
// for the full pieces, one for the last piece), the sharing step for each
// piece in turn, a drain state and the handoff. A rejected item (zero
// length, or count above length) skips the divisions and the sharing step.
// The result sits in an output register, so the next item is accepted
// while it waits. weight is unsigned Q16.16 and saturates at all ones; it
// reads zero when error is set.
module segmented_diagonal_weight (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [11:0] diag_length, [23:12] similar_count
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] weight
    output logic [0:0]       m_tuser    // [0] error
);
    import sdw_pkg::*;

    sdw_cmd_t    cmd;
    sdw_status_t status;
    logic        error;

    sdw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sdw_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_diag_length   (s_tdata[LEN_W-1:0]),
        .in_similar_count (s_tdata[LEN_W +: SIM_W]),
        .out_weight       (m_tdata),
        .out_error        (error)
    );

    assign m_tuser[0] = error;

endmodule
`default_nettype wire

/* rtl/sdw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdw_ctrl: sequencer
// Steps one item through range check, two short divisions, one piece per
// cycle and the output register handoff.
// ----------------------------------------------------------------------------
module sdw_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output sdw_pkg::sdw_cmd_t        cmd,
    input  wire sdw_pkg::sdw_status_t status
);
    import sdw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_DIV_FULL,
        ST_LOAD_LAST,
        ST_DIV_LAST,
        ST_PIECE,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.setup  = 1'b1;
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                if (status.bad) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.split  = 1'b1;
                    state_next = ST_DIV_FULL;
                end
            end
            ST_DIV_FULL: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_LOAD_LAST;
                end
            end
            ST_LOAD_LAST: begin
                cmd.div_load_last = 1'b1;
                state_next        = ST_DIV_LAST;
            end
            ST_DIV_LAST: begin
                cmd.div_step = 1'b1;
                cmd.div_last = 1'b1;
                if (status.div_done) begin
                    state_next = ST_PIECE;
                end
            end
            ST_PIECE: begin
                cmd.piece_step = 1'b1;
                cmd.piece_last = !status.more_full;
                if (!status.more_full) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hand off once the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/sdw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdw_datapath: range check, share divider, piece sharing and accumulation
// Holds the item, a restoring divider for the per-piece share, the carried
// remainder, the table lookup stage and the saturating total.
// ----------------------------------------------------------------------------
module sdw_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire sdw_pkg::sdw_cmd_t               cmd,
    output sdw_pkg::sdw_status_t                 status,
    input  wire logic [sdw_pkg::LEN_W-1:0]       in_diag_length,
    input  wire logic [sdw_pkg::SIM_W-1:0]       in_similar_count,
    output logic [sdw_pkg::WEIGHT_W-1:0]         out_weight,
    output logic                                 out_error
);
    import sdw_pkg::*;

    localparam weight_tbl_t WEIGHT_TBL = build_weight_tbl();

    // Item and derived values
    logic [LEN_W-1:0]    len_reg;
    logic [SIM_W-1:0]    sim_reg;
    logic                bad_reg;
    logic [LEN_W-1:0]    full_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [N_W-1:0]      last_reg;
    logic [LEN_W-1:0]    piece_cnt_reg;
    logic [RPROD_W-1:0]  recip_prod;

    // Divider
    logic [PROD_W-1:0]   div_rem_reg;
    logic [N_W-1:0]      div_q_reg;
    logic [IDX_W-1:0]    div_idx_reg;
    logic [PROD_W-1:0]   div_dvs;
    logic                div_ge;
    logic [PROD_W-1:0]   div_rem_next;
    logic [N_W-1:0]      div_q_next;
    logic [N_W-1:0]      q_full_reg;
    logic [LEN_W-1:0]    d_full_reg;
    logic [N_W-1:0]      q_last_reg;
    logic [LEN_W-1:0]    d_last_reg;

    // Piece sharing
    logic signed [REM_W-1:0] rem_reg;
    logic signed [REM_W-1:0] rem_next;
    logic signed [REM_W-1:0] share;
    logic signed [R1K_W-1:0] share_ext;
    logic signed [R1K_W-1:0] share_k;
    logic signed [R1K_W-1:0] thr_ext;
    logic                    round_up;
    logic [N_W-1:0]          q_sel;
    logic [LEN_W-1:0]        d_sel;
    logic [N_W-1:0]          n_sel;
    logic [CNT_W-1:0]        cnt_raw;
    logic [N_W-1:0]          cnt_sat;

    // Lookup and accumulate
    logic                    pc_vld_reg;
    logic [N_W-1:0]          pc_n_reg;
    logic [N_W-1:0]          pc_cnt_reg;
    logic [WEIGHT_W-1:0]     acc_reg;
    logic [WEIGHT_W-1:0]     entry;
    logic [WEIGHT_W:0]       acc_sum;

    logic [WEIGHT_W-1:0]     weight_reg;
    logic                    error_reg;

    assign recip_prod = RPROD_W'(len_reg) * RPROD_W'(RECIP);

    assign status.bad       = bad_reg;
    assign status.div_done  = (div_idx_reg == '0);
    assign status.more_full = (piece_cnt_reg != '0);

    // One restoring division step
    always_comb begin
        div_dvs      = PROD_W'(len_reg) << div_idx_reg;
        div_ge       = (div_rem_reg >= div_dvs);
        div_rem_next = div_ge ? (div_rem_reg - div_dvs) : div_rem_reg;
        div_q_next   = div_q_reg;
        div_q_next[div_idx_reg] = div_ge;
    end

    // Share of one piece plus carried remainder, round up near a whole count
    always_comb begin
        q_sel     = cmd.piece_last ? q_last_reg : q_full_reg;
        d_sel     = cmd.piece_last ? d_last_reg : d_full_reg;
        n_sel     = cmd.piece_last ? last_reg : N_W'(PIECE_LEN);
        share     = rem_reg + $signed({2'b00, d_sel});
        share_ext = R1K_W'(share);
        share_k   = share_ext * $signed(R1K_W'(THR_DEN));
        thr_ext   = $signed(R1K_W'(thr_reg));
        round_up  = (share_k >= thr_ext);
        cnt_raw   = CNT_W'(q_sel) + CNT_W'(round_up);
        cnt_sat   = (cnt_raw > CNT_W'(n_sel)) ? n_sel : N_W'(cnt_raw);
        rem_next  = round_up ? (share - $signed({2'b00, len_reg})) : share;
    end

    // Table lookup and saturating add
    always_comb begin
        entry   = WEIGHT_TBL[pc_n_reg][pc_cnt_reg];
        acc_sum = {1'b0, acc_reg} + {1'b0, entry};
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            len_reg <= in_diag_length;
            sim_reg <= in_similar_count;
        end
        if (cmd.setup) begin
            bad_reg  <= (len_reg == '0) || (sim_reg > len_reg) ||
                        (int'(len_reg) > MAX_DIAG);
            full_reg <= recip_prod[RECIP_SHIFT +: LEN_W];
            thr_reg  <= THR_W'(len_reg) * THR_W'(THR_NUM);
        end
        if (cmd.split) begin
            last_reg      <= N_W'(len_reg - LEN_W'(full_reg * LEN_W'(PIECE_LEN)));
            piece_cnt_reg <= full_reg;
            div_rem_reg   <= PROD_W'(sim_reg) * PROD_W'(PIECE_LEN);
            div_q_reg     <= '0;
            div_idx_reg   <= IDX_W'(N_W - 1);
            rem_reg       <= '0;
            acc_reg       <= '0;
        end
        if (cmd.div_load_last) begin
            div_rem_reg <= PROD_W'(sim_reg) * PROD_W'(last_reg);
            div_q_reg   <= '0;
            div_idx_reg <= IDX_W'(N_W - 1);
        end
        // Advance the divider, store quotient and remainder on the last step
        if (cmd.div_step) begin
            div_rem_reg <= div_rem_next;
            div_q_reg   <= div_q_next;
            div_idx_reg <= div_idx_reg - IDX_W'(1);
            if (div_idx_reg == '0) begin
                if (cmd.div_last) begin
                    q_last_reg <= div_q_next;
                    d_last_reg <= LEN_W'(div_rem_next);
                end else begin
                    q_full_reg <= div_q_next;
                    d_full_reg <= LEN_W'(div_rem_next);
                end
            end
        end
        if (cmd.piece_step) begin
            rem_reg    <= rem_next;
            pc_n_reg   <= n_sel;
            pc_cnt_reg <= cnt_sat;
            if (!cmd.piece_last) begin
                piece_cnt_reg <= piece_cnt_reg - LEN_W'(1);
            end
        end
        if (pc_vld_reg) begin
            acc_reg <= acc_sum[WEIGHT_W] ? '1 : acc_sum[WEIGHT_W-1:0];
        end
        if (cmd.result_load) begin
            weight_reg <= bad_reg ? '0 : acc_reg;
            error_reg  <= bad_reg;
        end
    end

    // Lookup stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_vld_reg <= 1'b0;
        end else begin
            pc_vld_reg <= cmd.piece_step;
        end
    end

    assign out_weight = weight_reg;
    assign out_error  = error_reg;

endmodule
`default_nettype wire
